[sv/buddy_page_allocator_top_macros.svh]
// Assertion macros for the allocator checker
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define BPA_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bpa_pkg.sv]
// Shared types, constants and helpers for the buddy page allocator
package bpa_pkg;

  localparam int TOP_ORDER     = 10;
  localparam int NUM_PAGES_DEF = 32768;
  localparam int ORD_W         = 4;
  localparam int NODE_W        = 15;
  localparam int PAGES_W       = 16;
  localparam int CNT_W         = 11;
  localparam int OP_W          = 2;
  localparam int LINK_W        = NODE_W + 1;
  localparam int LISTS         = TOP_ORDER + 1;

  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_REJECT = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [ORD_W-1:0]     order;
    logic [NODE_W-1:0]    blk;
    logic [PAGES_W-1:0]   pages;
  } cmd_t;

  // link store holds only pages below the managed limit
  function automatic logic node_in(input logic [NODE_W-1:0] n, input int unsigned np);
    return 32'(n) < np;
  endfunction

endpackage

[sv/bpa_ram.sv]
// Generic single-write, single-read RAM with registered read data
module bpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bpa_front.sv]
// Front end: decodes and checks each request, rounds the count to an order
module bpa_front import bpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic [OP_W-1:0]    op,
  input  logic [CNT_W-1:0]   page_count,
  input  logic [NODE_W-1:0]  block_index,
  input  logic [PAGES_W-1:0] page_limit,
  output cmd_t               cmd
);

  logic [PAGES_W-1:0] clipped;
  logic [ORD_W-1:0]   ord;
  logic               bad_cnt;

  always_comb begin
    clipped = (32'(page_limit) > 32'(NUM_PAGES)) ? PAGES_W'(NUM_PAGES) : page_limit;
    ord = '0;
    for (int k = 0; k < TOP_ORDER; k++) begin
      if (((CNT_W+1)'(1) << k) < (CNT_W+1)'(page_count)) begin
        ord = ORD_W'(k + 1);
      end
    end
    bad_cnt = (page_count == '0) ||
              ((CNT_W+1)'(page_count) > ((CNT_W+1)'(1) << TOP_ORDER));

    cmd.order = ord;
    cmd.blk   = block_index;
    cmd.pages = clipped;
    unique case (op)
      OP_INIT:  cmd.kind = CMD_INIT;
      OP_ALLOC: cmd.kind = bad_cnt ? CMD_REJECT : CMD_ALLOC;
      OP_FREE:  cmd.kind = (bad_cnt || (PAGES_W'(block_index) >= clipped)) ?
                           CMD_REJECT : CMD_FREE;
      default:  cmd.kind = CMD_REJECT;
    endcase
  end

endmodule

[sv/bpa_cmd_fifo.sv]
// Two-entry command queue between front and back ends
module bpa_cmd_fifo import bpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[sv/bpa_back.sv]
// Back end: free-list sequencer over the list heads and the link RAM
module bpa_back import bpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_avail,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [NODE_W-1:0]  result_index,
  output logic [ORD_W-1:0]   result_order
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int SW = $clog2(NUM_PAGES) + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_ARD    = 7'b0000100,
    S_APOP   = 7'b0001000,
    S_SPLIT  = 7'b0010000,
    S_FSTART = 7'b0100000,
    S_WRD    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [NODE_W-1:0]  heads [LISTS];
  logic [NODE_W-1:0]  heads_next [LISTS];
  logic [LISTS-1:0]   hvalid, hvalid_next;
  logic [ORD_W-1:0]   o, o_next;
  logic [ORD_W-1:0]   ord_req, ord_req_next;
  logic [NODE_W-1:0]  blk, blk_next;
  logic [NODE_W-1:0]  cur, cur_next;
  logic [NODE_W-1:0]  prev, prev_next;
  logic               cur_ok, cur_ok_next;
  logic               have_prev, have_prev_next;
  logic               chk, chk_next;
  logic [SW-1:0]      steps, steps_next;
  logic [PAGES_W-1:0] remaining, remaining_next;
  logic [PAGES_W-1:0] offset, offset_next;
  logic               out_valid_next, ok_next;
  logic [NODE_W-1:0]  result_index_next;
  logic [ORD_W-1:0]   result_order_next;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [LINK_W-1:0]  mem_wdata, mem_rdata;

  logic [NODE_W-1:0]  bud;
  logic               has_next;
  logic [NODE_W-1:0]  nxt;
  logic [PAGES_W:0]   size;
  logic               found;
  logic [ORD_W-1:0]   fo;
  logic [ORD_W-1:0]   om1;
  logic [NODE_W-1:0]  pnode;

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign bud      = blk ^ (NODE_W'(1) << o);
  assign has_next = mem_rdata[LINK_W-1] && node_in(cur, NUM_PAGES);
  assign nxt      = mem_rdata[NODE_W-1:0];
  assign om1      = o - ORD_W'(1);

  always_comb begin
    state_next        = state;
    heads_next        = heads;
    hvalid_next       = hvalid;
    o_next            = o;
    ord_req_next      = ord_req;
    blk_next          = blk;
    cur_next          = cur;
    prev_next         = prev;
    cur_ok_next       = cur_ok;
    have_prev_next    = have_prev;
    chk_next          = 1'b0;
    steps_next        = steps;
    remaining_next    = remaining;
    offset_next       = offset;
    out_valid_next    = out_valid & out_stall;
    ok_next           = ok;
    result_index_next = result_index;
    result_order_next = result_order;
    cmd_pop           = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;
    mem_raddr         = AW'(cur);
    size              = (PAGES_W+1)'(1) << o;
    found             = 1'b0;
    fo                = '0;
    pnode             = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_avail && !out_valid) begin
          cmd_pop      = 1'b1;
          ord_req_next = cmd.order;
          blk_next     = cmd.blk;
          o_next       = cmd.order;
          unique case (cmd.kind)
            CMD_INIT: begin
              hvalid_next    = '0;
              remaining_next = cmd.pages;
              offset_next    = '0;
              o_next         = ORD_W'(TOP_ORDER);
              state_next     = S_INIT;
            end
            CMD_ALLOC: begin
              for (int k = TOP_ORDER; k >= 0; k--) begin
                if (hvalid[k] && (ORD_W'(k) >= cmd.order)) begin
                  found = 1'b1;
                  fo    = ORD_W'(k);
                end
              end
              if (found) begin
                o_next     = fo;
                blk_next   = heads[fo];
                state_next = S_ARD;
              end else begin
                out_valid_next    = 1'b1;
                ok_next           = 1'b0;
                result_index_next = '0;
                result_order_next = '0;
              end
            end
            CMD_FREE: begin
              state_next = S_FSTART;
            end
            default: begin
              out_valid_next    = 1'b1;
              ok_next           = 1'b0;
              result_index_next = '0;
              result_order_next = '0;
            end
          endcase
        end
      end
      S_INIT: begin
        if ((PAGES_W+1)'(remaining) >= size) begin
          mem_we          = node_in(NODE_W'(offset), NUM_PAGES);
          mem_waddr       = AW'(NODE_W'(offset));
          mem_wdata       = {hvalid[o], heads[o]};
          heads_next[o]   = NODE_W'(offset);
          hvalid_next[o]  = 1'b1;
          offset_next     = offset + PAGES_W'(size);
          remaining_next  = remaining - PAGES_W'(size);
        end else if (o == '0) begin
          out_valid_next    = 1'b1;
          ok_next           = 1'b1;
          result_index_next = '0;
          result_order_next = '0;
          state_next        = S_IDLE;
        end else begin
          o_next = om1;
        end
      end
      S_ARD: begin
        mem_raddr  = AW'(blk);
        state_next = S_APOP;
      end
      S_APOP: begin
        if (mem_rdata[LINK_W-1] && node_in(blk, NUM_PAGES)) begin
          heads_next[o] = nxt;
        end else begin
          hvalid_next[o] = 1'b0;
        end
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (o > ord_req) begin
          // push the upper half of the split onto the next order down
          pnode            = blk ^ (NODE_W'(1) << om1);
          mem_we           = node_in(pnode, NUM_PAGES);
          mem_waddr        = AW'(pnode);
          mem_wdata        = {hvalid[om1], heads[om1]};
          heads_next[om1]  = pnode;
          hvalid_next[om1] = 1'b1;
          o_next           = om1;
        end else begin
          out_valid_next    = 1'b1;
          ok_next           = 1'b1;
          result_index_next = blk;
          result_order_next = ord_req;
          state_next        = S_IDLE;
        end
      end
      S_FSTART: begin
        if (o >= ORD_W'(TOP_ORDER)) begin
          mem_we                 = node_in(blk, NUM_PAGES);
          mem_waddr              = AW'(blk);
          mem_wdata              = {hvalid[TOP_ORDER], heads[TOP_ORDER]};
          heads_next[TOP_ORDER]  = blk;
          hvalid_next[TOP_ORDER] = 1'b1;
          out_valid_next         = 1'b1;
          ok_next                = 1'b1;
          result_index_next      = '0;
          result_order_next      = ord_req;
          state_next             = S_IDLE;
        end else begin
          cur_next       = heads[o];
          cur_ok_next    = hvalid[o];
          have_prev_next = 1'b0;
          steps_next     = '0;
          state_next     = S_WRD;
        end
      end
      S_WRD: begin
        if (chk) begin
          // link of cur is on the read port this cycle
          if (cur == bud) begin
            if (have_prev) begin
              mem_we    = node_in(prev, NUM_PAGES);
              mem_waddr = AW'(prev);
              mem_wdata = {has_next, has_next ? nxt : NODE_W'(0)};
            end else begin
              heads_next[o]  = has_next ? nxt : NODE_W'(0);
              hvalid_next[o] = has_next;
            end
            if (bud < blk) begin
              blk_next = bud;
            end
            o_next     = o + ORD_W'(1);
            state_next = S_FSTART;
          end else begin
            prev_next      = cur;
            have_prev_next = 1'b1;
            cur_next       = nxt;
            cur_ok_next    = has_next;
            steps_next     = steps + SW'(1);
          end
        end else if (!cur_ok || (steps == SW'(NUM_PAGES))) begin
          // buddy not on the list, or walk bound reached: park the block here
          mem_we            = node_in(blk, NUM_PAGES);
          mem_waddr         = AW'(blk);
          mem_wdata         = {hvalid[o], heads[o]};
          heads_next[o]     = blk;
          hvalid_next[o]    = 1'b1;
          out_valid_next    = 1'b1;
          ok_next           = 1'b1;
          result_index_next = '0;
          result_order_next = ord_req;
          state_next        = S_IDLE;
        end else begin
          mem_raddr = AW'(cur);
          chk_next  = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hvalid    <= '0;
      out_valid <= 1'b0;
      chk       <= 1'b0;
    end else begin
      state     <= state_next;
      hvalid    <= hvalid_next;
      out_valid <= out_valid_next;
      chk       <= chk_next;
    end
    heads        <= heads_next;
    o            <= o_next;
    ord_req      <= ord_req_next;
    blk          <= blk_next;
    cur          <= cur_next;
    prev         <= prev_next;
    cur_ok       <= cur_ok_next;
    have_prev    <= have_prev_next;
    steps        <= steps_next;
    remaining    <= remaining_next;
    offset       <= offset_next;
    ok           <= ok_next;
    result_index <= result_index_next;
    result_order <= result_order_next;
  end

endmodule

[sv/buddy_page_allocator_top.sv]
// Top level of the buddy page allocator
//
//   channel   direction  handshake               payload
//   request   in         in_valid / in_stall     op, page_count, block_index
//   result    out        out_valid / out_stall   ok, result_index, result_order
//   config    in         cfg_we                  cfg_wdata (page limit)
//
// Requests queue two deep in front of a sequencer that owns the list heads and
// the link RAM. Reject and out-of-memory answer from idle; init carves blocks
// from the top order down; alloc pops the smallest fitting list and splits down;
// free walks each list for the buddy, merging up, else parks the block there.
// Synchronous reset empties all lists at once; the link RAM needs no clearing.
// Result stall holds the sequencer before its next item; the queue keeps taking.
module buddy_page_allocator_top import bpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [CNT_W-1:0]   page_count,
  input  logic [NODE_W-1:0]  block_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [NODE_W-1:0]  result_index,
  output logic [ORD_W-1:0]   result_order,
  input  logic               cfg_we,
  input  logic [PAGES_W-1:0] cfg_wdata
);

  logic [PAGES_W-1:0] page_limit;
  cmd_t               front_cmd;
  cmd_t               head_cmd;
  logic               q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= PAGES_W'(32768);
    end else if (cfg_we) begin
      page_limit <= cfg_wdata;
    end
  end

  assign in_stall = q_full;

  bpa_front #(.NUM_PAGES(NUM_PAGES)) u_front (
    .op          (op),
    .page_count  (page_count),
    .block_index (block_index),
    .page_limit  (page_limit),
    .cmd         (front_cmd)
  );

  bpa_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && !q_full),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  bpa_back #(.NUM_PAGES(NUM_PAGES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_avail    (!q_empty),
    .cmd          (head_cmd),
    .cmd_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .result_index (result_index),
    .result_order (result_order)
  );

endmodule

[sv/bpa_checker.sv]
// Port-level checker for the buddy page allocator, bound to the top level
`include "buddy_page_allocator_top_macros.svh"

module bpa_checker import bpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              ok,
  input logic [NODE_W-1:0] result_index,
  input logic [ORD_W-1:0]  result_order
);

  `BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BPA_ASSERT_NOW(a_fail_zero, out_valid && !ok, result_index == '0 && result_order == '0, "failed transaction carries payload")
  `BPA_ASSERT_NOW(a_order_range, out_valid, result_order <= ORD_W'(TOP_ORDER), "order beyond top")
  `BPA_ASSERT_ALWAYS(a_rst_idle, rst, !out_valid, "result valid after reset")

endmodule

bind buddy_page_allocator_top bpa_checker u_chk (.*);
